// ----- sv/apch_pkg.sv -----
// Package for the angular pair-count histogram block.
// Holds sequencer, phase and clear-kind types, command and status codes,
// CORDIC constants and the stored record layouts. No dependencies.
package apch_pkg;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LROT, S_LWR, S_PAIR, S_FI, S_FJ, S_LJ, S_ROT,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_SQI, S_SQ, S_VI, S_VEC, S_SEP,
    S_DIV, S_HRD, S_HUPD, S_RESP
  } state_t;

  typedef enum logic [1:0] {PH_DD, PH_RR, PH_DR} phase_t;

  typedef enum logic [1:0] {CLR_RESET, CLR_ALL, CLR_COMPUTE} clr_kind_t;

  localparam logic [2:0] FUNC_LOAD_DATA = 3'd0;
  localparam logic [2:0] FUNC_LOAD_RAND = 3'd1;
  localparam logic [2:0] FUNC_COMPUTE   = 3'd2;
  localparam logic [2:0] FUNC_READ      = 3'd3;
  localparam logic [2:0] FUNC_CLEAR     = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_BIN = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  localparam logic [15:0] BIN_WIDTH_RESET = 16'd182;

  // reciprocal of the CORDIC gain, Q30
  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,
    30'd41,        30'd20,        30'd10,        30'd5,
    30'd3,         30'd1,         30'd1,         30'd0
  };

  typedef struct packed {
    logic [15:0]        ra;
    logic signed [31:0] fv;
    logic signed [31:0] s;
    logic signed [31:0] c;
  } dpt_t;

  typedef struct packed {
    logic [15:0]        ra;
    logic signed [31:0] s;
    logic signed [31:0] c;
  } rpt_t;

  typedef struct packed {
    logic [18:0]        dd;
    logic [18:0]        rr;
    logic [20:0]        dr;
    logic signed [63:0] ff;
  } hist_t;

endpackage

// ----- sv/apch_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the point stores and the histogram store. No dependencies.
module apch_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                             wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/angular_pair_count_histogram.sv -----
// Angular pair-count histogram: point stores, shared CORDIC / multiply / sqrt / divide
// sequencer and DD, RR, DR, FF histogram store. Depends on apch_pkg and apch_ram.
// A load runs the CORDIC rotation and then writes the point; bin reads and immediate
// answers go straight to the response. Compute first clears the histogram, then runs
// each pair through rotation, multiply, square root, vectoring (skipped when the pair's
// sine is zero), divide and bin update, all on the single shared datapath.
// One item at a time; a finished result may wait in the output register.
// Reset: synchronous; clears all MAX_BINS+1 histogram entries with in_stall high.
module angular_pair_count_histogram #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_BINS     = 256,
  parameter int CORDIC_STEPS = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic [15:0]        right_ascension,
  input  logic signed [15:0] declination,
  input  logic signed [31:0] field_value,
  input  logic [8:0]         bin_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [18:0]        dd_count,
  output logic [18:0]        rr_count,
  output logic [20:0]        dr_count,
  output logic signed [63:0] ff_sum
);
  import apch_pkg::*;

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int BW  = $clog2(MAX_BINS + 1);
  localparam logic [PCW-1:0] PT_MAX    = PCW'(MAX_POINTS);
  localparam logic [BW-1:0]  BIN_TOP   = BW'(MAX_BINS);
  localparam logic [4:0]     LAST_STEP = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0]     SQ_LAST   = 5'd30;
  localparam logic [4:0]     DIV_LAST  = 5'd15;

  state_t    state, state_next;
  phase_t    phase;
  clr_kind_t clr_kind;

  logic [15:0]    bin_width;
  logic [PCW-1:0] dcount, rcount, pi_idx, pj_idx;
  logic [BW-1:0]  clr_addr, bin;
  logic [4:0]     step;
  logic [1:0]     resp_status;
  logic           resp_read;
  logic           ld_rand;
  logic [15:0]    ld_ra;
  logic signed [31:0] ld_fv;

  dpt_t pi_pt, pj_pt;

  logic signed [33:0] cx, cy, cz;
  logic               cflip;
  logic signed [31:0] cr, tq, cval;
  logic signed [63:0] prod, acc, ffp;
  logic [60:0]        sq_v, sq_bit;
  logic [61:0]        sq_r;
  logic [15:0]        dv_n, dv_rem, quo;

  // RAM ports
  logic           dram_we, dram_re, rram_we, rram_re, hram_we, hram_re;
  logic [AW-1:0]  dram_waddr, dram_raddr, rram_waddr, rram_raddr;
  logic [BW-1:0]  hram_waddr, hram_raddr;
  dpt_t           dram_wdata, drd;
  rpt_t           rram_wdata, rrd;
  hist_t          hram_wdata, hrd, upd;

  apch_ram #(.W($bits(dpt_t)), .DEPTH(MAX_POINTS)) u_dram (
    .clk(clk), .we(dram_we), .waddr(dram_waddr), .wdata(dram_wdata),
    .re(dram_re), .raddr(dram_raddr), .rdata(drd)
  );

  apch_ram #(.W($bits(rpt_t)), .DEPTH(MAX_POINTS)) u_rram (
    .clk(clk), .we(rram_we), .waddr(rram_waddr), .wdata(rram_wdata),
    .re(rram_re), .raddr(rram_raddr), .rdata(rrd)
  );

  apch_ram #(.W($bits(hist_t)), .DEPTH(MAX_BINS + 1)) u_hram (
    .clk(clk), .we(hram_we), .waddr(hram_waddr), .wdata(hram_wdata),
    .re(hram_re), .raddr(hram_raddr), .rdata(hrd)
  );

  // decode helpers
  logic accept, full_d, full_r, bad_bin, out_free, pair_go, jwrap;
  logic [PCW-1:0] jmax;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign full_d    = dcount >= PT_MAX;
  assign full_r    = rcount >= PT_MAX;
  assign bad_bin   = 32'(bin_index) > 32'(MAX_BINS);
  assign out_free  = !out_valid || !out_stall;
  assign jmax      = (phase == PH_DR) ? rcount : pi_idx;
  assign jwrap     = (pj_idx + PCW'(1)) == jmax;

  always_comb begin
    case (phase)
      PH_DD:   pair_go = pi_idx < dcount;
      PH_RR:   pair_go = pi_idx < rcount;
      PH_DR:   pair_go = (pi_idx < dcount) && (rcount != '0);
      default: pair_go = 1'b0;
    endcase
  end

  // CORDIC step, shared by rotation and vectoring
  logic signed [33:0] sh_x, sh_y, atan_s, cx_step, cy_step, cz_step;
  logic               c_pos;

  always_comb begin
    sh_x   = cx >>> step;
    sh_y   = cy >>> step;
    atan_s = $signed({4'b0, ATAN_TAB[step]});
    c_pos  = (state == S_VEC) ? !(cy > 34'sd0) : !cz[33];
    if (c_pos) begin
      cx_step = cx - sh_y;
      cy_step = cy + sh_x;
      cz_step = cz - atan_s;
    end else begin
      cx_step = cx + sh_y;
      cy_step = cy - sh_x;
      cz_step = cz + atan_s;
    end
  end

  // rotation start: fold into the half turn around zero
  logic [15:0]        rot_hi;
  logic [31:0]        ang_in, ang_f;
  logic               flip_in;
  logic signed [33:0] z_in;
  logic [15:0]        pj_ra_rd;

  assign pj_ra_rd = (phase == PH_DD) ? drd.ra : rrd.ra;
  assign rot_hi   = (state == S_IDLE) ? declination : (pi_pt.ra - pj_ra_rd);
  assign ang_in   = {rot_hi, 16'h0};
  assign flip_in  = ang_in[31] ^ ang_in[30];
  assign ang_f    = flip_in ? {~ang_in[31], ang_in[30:0]} : ang_in;
  assign z_in     = $signed({{2{ang_f[31]}}, ang_f});

  logic signed [33:0] cos_w, sin_w;
  assign cos_w = cflip ? -cx : cx;
  assign sin_w = cflip ? -cy : cy;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  always_comb begin
    case (state)
      S_M1: begin
        mul_a = pi_pt.c;
        mul_b = pj_pt.c;
      end
      S_M2: begin
        mul_a = pi_pt.s;
        mul_b = pj_pt.s;
      end
      S_M3: begin
        mul_a = tq;
        mul_b = cr;
      end
      S_M5: begin
        mul_a = cval;
        mul_b = cval;
      end
      S_SQI: begin
        mul_a = pi_pt.fv;
        mul_b = pj_pt.fv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // cosine of separation, clamped
  logic signed [63:0] csum, csh, cclamp;
  always_comb begin
    csum = acc + prod;
    csh  = csum >>> 30;
    if (csh > 64'sd1073741824) begin
      cclamp = 64'sd1073741824;
    end else if (csh < -64'sd1073741824) begin
      cclamp = -64'sd1073741824;
    end else begin
      cclamp = csh;
    end
  end

  // square root step
  logic [62:0] sq_sum;
  logic        sq_ge;
  assign sq_sum = {1'b0, sq_r} + {2'b0, sq_bit};
  assign sq_ge  = {2'b0, sq_v} >= sq_sum;

  logic signed [33:0] cval_x, cabs;
  assign cval_x = {{2{cval[31]}}, cval};
  assign cabs   = cval[31] ? -cval_x : cval_x;

  // separation
  logic [30:0] zc;
  logic [31:0] sep;
  always_comb begin
    if (cz[33]) begin
      zc = '0;
    end else if (cz > 34'sd1073741824) begin
      zc = 31'h4000_0000;
    end else begin
      zc = cz[30:0];
    end
    sep = cval[31] ? (32'h8000_0000 - {1'b0, zc}) : {1'b0, zc};
  end

  // divide step
  logic [15:0] wsafe, dv_rem_new;
  logic [16:0] dv_trial;
  logic        dv_ge;
  assign wsafe      = (bin_width == '0) ? 16'd1 : bin_width;
  assign dv_trial   = {dv_rem, dv_n[15]};
  assign dv_ge      = dv_trial >= {1'b0, wsafe};
  assign dv_rem_new = dv_ge ? 16'(dv_trial - {1'b0, wsafe}) : dv_trial[15:0];

  logic [BW-1:0] bin_c;
  assign bin_c = (32'(quo) > 32'(MAX_BINS)) ? BIN_TOP : BW'(quo);

  // histogram update
  logic signed [63:0] ff_add;
  always_comb begin
    upd    = hrd;
    ff_add = hrd.ff + ffp;
    case (phase)
      PH_DD: begin
        if (hrd.dd != '1) begin
          upd.dd = hrd.dd + 19'd1;
        end
        if ((hrd.ff[63] == ffp[63]) && (ff_add[63] != hrd.ff[63])) begin
          upd.ff = ffp[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
          upd.ff = ff_add;
        end
      end
      PH_RR: begin
        if (hrd.rr != '1) begin
          upd.rr = hrd.rr + 19'd1;
        end
      end
      PH_DR: begin
        if (hrd.dr != '1) begin
          upd.dr = hrd.dr + 21'd1;
        end
      end
      default: upd = hrd;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR: begin
        if (clr_addr == BIN_TOP) begin
          case (clr_kind)
            CLR_RESET:   state_next = S_IDLE;
            CLR_ALL:     state_next = S_RESP;
            CLR_COMPUTE: state_next = S_PAIR;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_LOAD_DATA: state_next = full_d ? S_RESP : S_LROT;
            FUNC_LOAD_RAND: state_next = full_r ? S_RESP : S_LROT;
            FUNC_COMPUTE:   state_next = S_CLR;
            FUNC_CLEAR:     state_next = S_CLR;
            default:        state_next = S_RESP;
          endcase
        end
      end
      S_LROT:  if (step == LAST_STEP) state_next = S_LWR;
      S_LWR:   state_next = S_RESP;
      S_PAIR: begin
        if (pair_go) begin
          state_next = S_FI;
        end else if (phase == PH_DR) begin
          state_next = S_RESP;
        end
      end
      S_FI:    state_next = S_FJ;
      S_FJ:    state_next = S_LJ;
      S_LJ:    state_next = S_ROT;
      S_ROT:   if (step == LAST_STEP) state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_M4;
      S_M4:    state_next = S_M5;
      S_M5:    state_next = S_SQI;
      S_SQI:   state_next = S_SQ;
      S_SQ:    if (step == SQ_LAST) state_next = S_VI;
      S_VI:    state_next = (sq_r == '0) ? S_SEP : S_VEC;
      S_VEC:   if (step == LAST_STEP) state_next = S_SEP;
      S_SEP:   state_next = S_DIV;
      S_DIV:   if (step == DIV_LAST) state_next = S_HRD;
      S_HRD:   state_next = S_HUPD;
      S_HUPD:  state_next = S_PAIR;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM and handshake controls
  always_comb begin
    in_stall   = state != S_IDLE;
    dram_we    = (state == S_LWR) && !ld_rand;
    rram_we    = (state == S_LWR) && ld_rand;
    dram_waddr = dcount[AW-1:0];
    rram_waddr = rcount[AW-1:0];
    dram_wdata = '{ra: ld_ra, fv: ld_fv, s: sin_w[31:0], c: cos_w[31:0]};
    rram_wdata = '{ra: ld_ra, s: sin_w[31:0], c: cos_w[31:0]};
    dram_re    = 1'b0;
    rram_re    = 1'b0;
    dram_raddr = pi_idx[AW-1:0];
    rram_raddr = pi_idx[AW-1:0];
    if (state == S_FI) begin
      dram_re = phase != PH_RR;
      rram_re = phase == PH_RR;
    end else if (state == S_FJ) begin
      dram_re    = phase == PH_DD;
      rram_re    = phase != PH_DD;
      dram_raddr = pj_idx[AW-1:0];
      rram_raddr = pj_idx[AW-1:0];
    end
    hram_we    = (state == S_CLR) || (state == S_HUPD);
    hram_waddr = (state == S_CLR) ? clr_addr : bin;
    hram_wdata = (state == S_CLR) ? '0 : upd;
    hram_re    = 1'b0;
    hram_raddr = bin_c;
    if (state == S_HRD) begin
      hram_re = 1'b1;
    end else if (accept && (func == FUNC_READ) && !bad_bin) begin
      hram_re    = 1'b1;
      hram_raddr = BW'(bin_index);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_kind  <= CLR_RESET;
      clr_addr  <= '0;
      dcount    <= '0;
      rcount    <= '0;
      bin_width <= BIN_WIDTH_RESET;
      out_valid <= 1'b0;
      step      <= '0;
      phase     <= PH_DD;
      pi_idx    <= '0;
      pj_idx    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        bin_width <= cfg_data;
      end
      if ((state == S_RESP) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + BW'(1);
          if ((clr_addr == BIN_TOP) && (clr_kind == CLR_COMPUTE)) begin
            phase  <= PH_DD;
            pi_idx <= PCW'(1);
            pj_idx <= '0;
          end
        end
        S_IDLE: begin
          clr_addr <= '0;
          step     <= '0;
          if (accept) begin
            case (func)
              FUNC_COMPUTE: clr_kind <= CLR_COMPUTE;
              FUNC_CLEAR: begin
                clr_kind <= CLR_ALL;
                dcount   <= '0;
                rcount   <= '0;
              end
              default: clr_kind <= clr_kind;
            endcase
          end
        end
        S_LWR: begin
          if (ld_rand) begin
            rcount <= rcount + PCW'(1);
          end else begin
            dcount <= dcount + PCW'(1);
          end
        end
        S_PAIR: begin
          if (!pair_go) begin
            case (phase)
              PH_DD: begin
                phase  <= PH_RR;
                pi_idx <= PCW'(1);
                pj_idx <= '0;
              end
              PH_RR: begin
                phase  <= PH_DR;
                pi_idx <= '0;
                pj_idx <= '0;
              end
              default: phase <= phase;
            endcase
          end
        end
        S_LROT, S_ROT, S_SQ, S_VEC, S_DIV: step <= step + 5'd1;
        S_LJ, S_SQI, S_VI, S_SEP: step <= '0;
        S_HUPD: begin
          if (jwrap) begin
            pj_idx <= '0;
            pi_idx <= pi_idx + PCW'(1);
          end else begin
            pj_idx <= pj_idx + PCW'(1);
          end
        end
        default: step <= step;
      endcase
    end
  end

  // arithmetic shift by 30, kept to 32 bits
  function automatic logic signed [31:0] csh_t(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v >>> 30;
    return t[31:0];
  endfunction

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_CLR: begin
        resp_status <= (clr_kind == CLR_COMPUTE) ? ST_DONE : ST_OK;
        resp_read   <= 1'b0;
      end
      S_IDLE: begin
        ld_ra   <= right_ascension;
        ld_fv   <= field_value;
        ld_rand <= func == FUNC_LOAD_RAND;
        cx      <= INV_GAIN;
        cy      <= '0;
        cz      <= z_in;
        cflip   <= flip_in;
        case (func)
          FUNC_LOAD_DATA: begin
            resp_status <= full_d ? ST_FULL : ST_OK;
            resp_read   <= 1'b0;
          end
          FUNC_LOAD_RAND: begin
            resp_status <= full_r ? ST_FULL : ST_OK;
            resp_read   <= 1'b0;
          end
          FUNC_READ: begin
            resp_status <= bad_bin ? ST_BAD_BIN : ST_OK;
            resp_read   <= !bad_bin;
          end
          default: begin
            resp_status <= ST_OK;
            resp_read   <= 1'b0;
          end
        endcase
      end
      S_LROT, S_ROT, S_VEC: begin
        cx <= cx_step;
        cy <= cy_step;
        cz <= cz_step;
      end
      S_LWR: begin
        resp_status <= ST_OK;
        resp_read   <= 1'b0;
      end
      S_PAIR: begin
        resp_status <= ST_DONE;
        resp_read   <= 1'b0;
      end
      S_FJ: begin
        if (phase == PH_RR) begin
          pi_pt <= '{ra: rrd.ra, fv: '0, s: rrd.s, c: rrd.c};
        end else begin
          pi_pt <= drd;
        end
      end
      S_LJ: begin
        if (phase == PH_DD) begin
          pj_pt <= drd;
        end else begin
          pj_pt <= '{ra: rrd.ra, fv: '0, s: rrd.s, c: rrd.c};
        end
        cx    <= INV_GAIN;
        cy    <= '0;
        cz    <= z_in;
        cflip <= flip_in;
      end
      S_M1: begin
        cr   <= cos_w[31:0];
        prod <= mul_p;
      end
      S_M2: begin
        tq   <= csh_t(prod);
        prod <= mul_p;
      end
      S_M3: begin
        acc  <= prod;
        prod <= mul_p;
      end
      S_M4: cval <= cclamp[31:0];
      S_M5: prod <= mul_p;
      S_SQI: begin
        sq_v   <= 61'((64'sd1 <<< 60) - prod);
        sq_r   <= '0;
        sq_bit <= {1'b1, 60'b0};
        ffp    <= mul_p;
      end
      S_SQ: begin
        if (sq_ge) begin
          sq_v <= sq_v - sq_sum[60:0];
          sq_r <= (sq_r >> 1) + {1'b0, sq_bit};
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_VI: begin
        cx <= cabs;
        cy <= $signed({3'b0, sq_r[30:0]});
        cz <= '0;
      end
      S_SEP: begin
        dv_n   <= sep[31:16];
        dv_rem <= '0;
        quo    <= '0;
      end
      S_DIV: begin
        dv_rem <= dv_rem_new;
        dv_n   <= {dv_n[14:0], 1'b0};
        quo    <= {quo[14:0], dv_ge};
      end
      S_HRD: bin <= bin_c;
      S_RESP: begin
        if (out_free) begin
          status   <= resp_status;
          dd_count <= resp_read ? hrd.dd : '0;
          rr_count <= resp_read ? hrd.rr : '0;
          dr_count <= resp_read ? hrd.dr : '0;
          ff_sum   <= resp_read ? hrd.ff : '0;
        end
      end
      default: cflip <= cflip;
    endcase
  end

endmodule
